// File: hw/rtl/rbr_pkg.sv
// shared types and constants of the retransmit byte ring
package rbr_pkg;

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_DROP = 2'd1;
    localparam logic [1:0] OP_PEEK = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int LEN_W       = 13;

    typedef struct packed {
        logic             wr_en;
        logic             rd_en;
        logic [7:0]       wr_data;
        logic             push_accepted;
        logic [LEN_W-1:0] dropped_count;
        logic [LEN_W-1:0] granted_length;
        logic [LEN_W-1:0] free_room;
        logic [LEN_W-1:0] stored_length;
    } t_cmd;

endpackage

// File: hw/rtl/rbr_if.sv
// handshake channels of the retransmit byte ring
interface rbr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [7:0]  data_byte;
    logic [12:0] count;
    logic        chunk_start;
    logic [11:0] peek_offset;

    modport source (output valid, output operation, output data_byte, output count,
                    output chunk_start, output peek_offset, input ready);
    modport sink (input valid, input operation, input data_byte, input count,
                  input chunk_start, input peek_offset, output ready);
endinterface

interface rbr_out_if;
    logic        valid;
    logic        ready;
    logic        push_accepted;
    logic [12:0] dropped_count;
    logic [12:0] granted_length;
    logic [7:0]  peek_byte;
    logic [12:0] free_room;
    logic [12:0] stored_length;

    modport source (output valid, output push_accepted, output dropped_count,
                    output granted_length, output peek_byte, output free_room,
                    output stored_length, input ready);
    modport sink (input valid, input push_accepted, input dropped_count,
                  input granted_length, input peek_byte, input free_room,
                  input stored_length, output ready);
endinterface

interface rbr_cfg_if;
    logic        valid;
    logic        ready;
    logic [12:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/rbr_ram.sv
// generic single write port, single read port ram with registered read
module rbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/rbr_queue.sv
// short fifo between the front and back parts
module rbr_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    import rbr_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0] r_slot [QUEUE_DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [PW:0]      r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == (PW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/rbr_front.sv
// front part: takes words, keeps head, length and chunk state, issues commands
module rbr_front #(
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    rbr_in_if.sink                   i_in,
    rbr_cfg_if.sink                  i_cfg,
    input  logic                     i_queue_full,
    output logic                     o_push,
    output rbr_pkg::t_cmd            o_cmd,
    output logic [$clog2(DEPTH)-1:0] o_addr
);

    import rbr_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > LEN_W) ? CW : LEN_W;
    localparam int EW = LW + 1;

    logic [AW-1:0] r_head, n_head;
    logic [LW-1:0] r_held, n_held;
    logic          r_ok, n_ok;
    logic [LW-1:0] r_left, n_left;
    logic [LW-1:0] r_cap, n_cap;

    logic          accept;
    logic [LW-1:0] count_x;
    logic [LW-1:0] head_x;
    logic [LW-1:0] cfg_x;
    logic [LW-1:0] left_v;
    logic          ok_v;
    logic [EW-1:0] sum;
    logic [LW-1:0] take;
    logic [LW-1:0] contig;
    logic [LW-1:0] grant;
    t_cmd          cmd;
    logic [AW-1:0] addr;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !i_queue_full && !i_cfg.valid;
    assign accept      = i_in.valid && i_in.ready;
    assign count_x     = LW'(i_in.count);
    assign head_x      = LW'(r_head);
    assign cfg_x       = LW'(i_cfg.data);

    always_comb begin
        n_head = r_head;
        n_held = r_held;
        n_ok   = r_ok;
        n_left = r_left;
        n_cap  = r_cap;
        left_v = r_left;
        ok_v   = r_ok;
        sum    = '0;
        take   = '0;
        contig = '0;
        grant  = '0;
        addr   = '0;
        cmd    = '0;
        cmd.wr_data = i_in.data_byte;
        if (i_cfg.valid) begin
            if (cfg_x == '0) begin
                n_cap = LW'(1);
            end else if (cfg_x > LW'(DEPTH)) begin
                n_cap = LW'(DEPTH);
            end else begin
                n_cap = cfg_x;
            end
            n_head = '0;
            n_held = '0;
            n_ok   = 1'b0;
            n_left = '0;
        end else if (accept) begin
            unique case (i_in.operation)
                OP_PUSH: begin
                    if (i_in.chunk_start) begin
                        left_v = count_x;
                        ok_v   = (count_x <= r_cap - r_held);
                    end
                    n_left = left_v;
                    n_ok   = ok_v;
                    if (ok_v && left_v != '0 && r_held < r_cap) begin
                        sum = EW'(head_x) + EW'(r_held);
                        if (sum >= EW'(r_cap)) begin
                            sum = sum - EW'(r_cap);
                        end
                        addr              = AW'(sum);
                        cmd.wr_en         = 1'b1;
                        cmd.push_accepted = 1'b1;
                        n_held            = r_held + 1'b1;
                        n_left            = left_v - 1'b1;
                    end
                end
                OP_DROP: begin
                    take = (count_x > r_held) ? r_held : count_x;
                    sum  = EW'(head_x) + EW'(take);
                    if (sum >= EW'(r_cap)) begin
                        sum = sum - EW'(r_cap);
                    end
                    n_head            = AW'(sum);
                    n_held            = r_held - take;
                    cmd.dropped_count = LEN_W'(take);
                end
                OP_PEEK: begin
                    if (r_held != '0) begin
                        contig = r_cap - head_x;
                        grant  = (count_x > r_held) ? r_held : count_x;
                        if (grant > contig) begin
                            grant = contig;
                        end
                        sum                = EW'(head_x) + EW'(i_in.peek_offset);
                        addr               = AW'(sum);
                        cmd.rd_en          = (LW'(i_in.peek_offset) < grant);
                        cmd.granted_length = LEN_W'(grant);
                    end
                end
                default: begin
                end
            endcase
        end
        cmd.free_room     = LEN_W'(n_cap - n_held);
        cmd.stored_length = LEN_W'(n_held);
    end

    assign o_push = accept;
    assign o_cmd  = cmd;
    assign o_addr = addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_held <= '0;
            r_ok   <= 1'b0;
            r_left <= '0;
            r_cap  <= LW'(DEPTH);
        end else begin
            r_head <= n_head;
            r_held <= n_held;
            r_ok   <= n_ok;
            r_left <= n_left;
            r_cap  <= n_cap;
        end
    end

endmodule

// File: hw/rtl/rbr_back.sv
// back part: byte store access and output register
module rbr_back #(
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_empty,
    input  rbr_pkg::t_cmd            i_cmd,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    output logic                     o_pop,
    rbr_out_if.source                o_out
);

    import rbr_pkg::*;

    logic       r_s1_valid;
    t_cmd       r_s1_cmd;
    logic       r_out_valid;
    t_cmd       r_out_cmd;
    logic [7:0] r_out_byte;
    logic       out_free;
    logic       s1_move;
    logic       pop;
    logic [7:0] rd_data;

    assign out_free = !r_out_valid || o_out.ready;
    assign s1_move  = r_s1_valid && out_free;
    assign pop      = !i_empty && (!r_s1_valid || s1_move);
    assign o_pop    = pop;

    rbr_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (pop && i_cmd.wr_en),
        .i_wr_addr (i_addr),
        .i_wr_data (i_cmd.wr_data),
        .i_rd_en   (pop && i_cmd.rd_en),
        .i_rd_addr (i_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_s1_cmd <= i_cmd;
        end
        if (s1_move) begin
            r_out_cmd  <= r_s1_cmd;
            r_out_byte <= r_s1_cmd.rd_en ? rd_data : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.push_accepted  = r_out_cmd.push_accepted;
    assign o_out.dropped_count  = r_out_cmd.dropped_count;
    assign o_out.granted_length = r_out_cmd.granted_length;
    assign o_out.peek_byte      = r_out_byte;
    assign o_out.free_room      = r_out_cmd.free_room;
    assign o_out.stored_length  = r_out_cmd.stored_length;

endmodule

// File: hw/rtl/retransmit_byte_ring.sv
// top level of the retransmit byte ring
// Ring of unacknowledged bytes with a capacity of 1 to DEPTH bytes, set through the
// configuration channel while idle (a write empties the ring; zero counts as 1, values
// above DEPTH as DEPTH). Every input word (push, drop or peek) gives exactly one result
// word. One word is taken per cycle for as long as the output side keeps up and no
// configuration write is pending; the front part updates head, length and chunk state
// when the word is taken and queues a command, which passes through the queue and then
// the single read port of the byte store, whose registered read feeds the output
// register. The four-entry queue between the two parts absorbs
// output stalls. The byte store has no reset and needs no clearing pass, so words are
// taken from the first cycle after reset.
module retransmit_byte_ring #(
    parameter int DEPTH = 4096
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rbr_cfg_if.sink   i_cfg,
    rbr_in_if.sink    i_in,
    rbr_out_if.source o_out
);

    import rbr_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int QW = $bits(t_cmd) + AW;

    logic          f_push;
    t_cmd          f_cmd;
    logic [AW-1:0] f_addr;
    logic          q_full;
    logic          q_empty;
    logic          q_pop;
    logic [QW-1:0] q_data;
    t_cmd          b_cmd;
    logic [AW-1:0] b_addr;

    rbr_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_cfg        (i_cfg),
        .i_queue_full (q_full),
        .o_push       (f_push),
        .o_cmd        (f_cmd),
        .o_addr       (f_addr)
    );

    rbr_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  ({f_cmd, f_addr}),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    assign {b_cmd, b_addr} = q_data;

    rbr_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_cmd   (b_cmd),
        .i_addr  (b_addr),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

endmodule

// File: hw/rtl/rbr_checker.sv
// port-level checks of the retransmit byte ring and their bind
module rbr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_push_accepted,
    input logic [12:0] i_dropped_count,
    input logic [12:0] i_granted_length,
    input logic [7:0]  i_peek_byte,
    input logic [12:0] i_stored_length
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word valid right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word withdrawn while stalled");

    a_one_operation: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_push_accepted || i_dropped_count != 13'd0)
        |-> i_granted_length == 13'd0 && !(i_push_accepted && i_dropped_count != 13'd0))
        else $error("result word mixes operations");

    a_byte_needs_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_peek_byte != 8'd0 |-> i_granted_length != 13'd0)
        else $error("peek byte outside any grant");

    a_grant_within_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_granted_length <= i_stored_length)
        else $error("grant exceeds stored length");

endmodule

bind retransmit_byte_ring rbr_checker u_rbr_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_push_accepted  (o_out.push_accepted),
    .i_dropped_count  (o_out.dropped_count),
    .i_granted_length (o_out.granted_length),
    .i_peek_byte      (o_out.peek_byte),
    .i_stored_length  (o_out.stored_length)
);

// File: verif/retransmit_byte_ring_tb.sv
// self-checking testbench for the retransmit byte ring
`timescale 1ns / 100ps

module retransmit_byte_ring_tb;

    import rbr_pkg::*;

    localparam logic [1:0] OP_NOP = 2'd3;
    localparam int RING_DEPTH      = 4096;
    localparam int WORDS_PER_PHASE = 105;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int TAIL_CYCLES     = 20;
    localparam int REPORT_LIMIT    = 10;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  data;
        logic [12:0] count;
        logic        start;
        logic [11:0] offset;
    } t_req_word;

    typedef struct packed {
        logic        push_accepted;
        logic [12:0] dropped_count;
        logic [12:0] granted_length;
        logic [7:0]  peek_byte;
        logic [12:0] free_room;
        logic [12:0] stored_length;
    } t_res_word;

    typedef struct packed {
        t_req_word w;
        logic      known;
        t_res_word res;
    } t_probe_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rbr_cfg_if cfg_ch ();
    rbr_in_if  in_ch ();
    rbr_out_if out_ch ();

    retransmit_byte_ring #(
        .DEPTH(RING_DEPTH)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_ch),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ring state as the block should hold it
    logic [7:0]  ring_bytes [0:RING_DEPTH-1];
    logic [12:0] ring_capacity = 13'(RING_DEPTH);
    int unsigned ring_head       = 0;
    int unsigned ring_held       = 0;
    bit          ring_chunk_ok   = 1'b0;
    int unsigned ring_chunk_left = 0;

    t_res_word   pending_results [$];
    t_probe_row  probe_tab [$];
    int unsigned cap_plan [10] = '{0, 1, 8191, 5, 37, 4096, 2, 300, 13, 4095};

    int unsigned fail_count      = 0;
    int unsigned idle_cycles     = 0;
    int unsigned calm_words      = 0;
    int unsigned stall_left      = 0;
    int unsigned calm_cycles     = 0;
    bit          word_known      = 1'b0;
    t_res_word   word_known_res  = '0;

    function automatic int unsigned cap_in_use();
        int unsigned c;
        c = ring_capacity;
        if (c == 0) c = 1;
        if (c > RING_DEPTH) c = RING_DEPTH;
        return c;
    endfunction

    function automatic t_res_word ring_advance(input t_req_word w);
        t_res_word   r;
        int unsigned cap, tail, n, contig, grant;
        r = '0;
        cap = cap_in_use();
        case (w.op)
            OP_PUSH: begin
                if (w.start) begin
                    ring_chunk_left = w.count;
                    ring_chunk_ok = (w.count <= cap - ring_held);
                end
                if (ring_chunk_ok && ring_chunk_left > 0 && ring_held < cap) begin
                    tail = ring_head + ring_held;
                    if (tail >= cap) tail -= cap;
                    ring_bytes[tail] = w.data;
                    ring_held++;
                    ring_chunk_left--;
                    r.push_accepted = 1'b1;
                end
            end
            OP_DROP: begin
                n = w.count;
                if (n > ring_held) n = ring_held;
                ring_head += n;
                if (ring_head >= cap) ring_head -= cap;
                ring_held -= n;
                r.dropped_count = 13'(n);
            end
            OP_PEEK: begin
                if (ring_held != 0) begin
                    contig = cap - ring_head;
                    grant = w.count;
                    if (grant > ring_held) grant = ring_held;
                    if (grant > contig) grant = contig;
                    r.granted_length = 13'(grant);
                    if (w.offset < grant) r.peek_byte = ring_bytes[ring_head + w.offset];
                end
            end
            default: ;
        endcase
        r.free_room = 13'(cap - ring_held);
        r.stored_length = 13'(ring_held);
        return r;
    endfunction

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // mostly well-formed chunks with drops and peeks around them
    function automatic t_req_word pick_word();
        t_req_word   w;
        int unsigned room, r, lim;
        room = cap_in_use() - ring_held;
        w.op = OP_PUSH;
        w.data = 8'($urandom);
        w.count = 13'($urandom);
        w.start = 1'b0;
        w.offset = 12'($urandom);
        r = $urandom_range(0, 99);
        if (ring_chunk_ok && ring_chunk_left != 0 && r < 70) return w;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            w.start = 1'b1;
            r = $urandom_range(0, 99);
            lim = (room > 12) ? 12 : room;
            if (room == 0 && r < 70) w.count = 13'd1;
            else if (r < 60) w.count = 13'($urandom_range(1, lim));
            else if (r < 70) w.count = 13'($urandom_range(1, room));
            else if (r < 80) w.count = '0;
            else if (r < 95) w.count = 13'($urandom_range(room + 1, room + 8));
        end else if (r < 60) begin
            w.op = OP_DROP;
            r = $urandom_range(0, 99);
            lim = (ring_held > 6) ? 6 : ring_held;
            if (r < 60) w.count = 13'($urandom_range(0, lim));
            else if (r < 80) w.count = 13'(ring_held);
            else if (r < 90) w.count = 13'($urandom_range(0, ring_held));
        end else if (r < 90) begin
            w.op = OP_PEEK;
            r = $urandom_range(0, 99);
            if (r < 60) w.count = 13'($urandom_range(0, ring_held + 2));
            else if (r < 85) w.count = '1;
            lim = (ring_held + 1 > 4095) ? 4095 : ring_held + 1;
            if ($urandom_range(0, 99) < 70) w.offset = 12'($urandom_range(0, lim));
        end else if (r < 96) begin
            w.start = 1'b0;
        end else begin
            w.op = OP_NOP;
            w.start = 1'($urandom);
        end
        return w;
    endfunction

    function automatic void add_probe(input logic [1:0] op, input int data, input int cnt,
                                      input bit st, input int off, input bit known,
                                      input int acc, input int fr, input int sl);
        t_probe_row p;
        p.w.op = op;
        p.w.data = data[7:0];
        p.w.count = cnt[12:0];
        p.w.start = st;
        p.w.offset = off[11:0];
        p.known = known;
        p.res = '0;
        p.res.push_accepted = acc[0];
        p.res.free_room = fr[12:0];
        p.res.stored_length = sl[12:0];
        probe_tab.push_back(p);
    endfunction

    task automatic note_failure(input string why, input t_res_word want, input t_res_word got);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("%s: expected acc=%0d drop=%0d grant=%0d byte=%02h free=%0d held=%0d",
                     why, want.push_accepted, want.dropped_count, want.granted_length,
                     want.peek_byte, want.free_room, want.stored_length);
            $display("    got acc=%0d drop=%0d grant=%0d byte=%02h free=%0d held=%0d",
                     got.push_accepted, got.dropped_count, got.granted_length,
                     got.peek_byte, got.free_room, got.stored_length);
        end
    endtask

    task automatic write_capacity(input logic [12:0] value);
        cfg_ch.data <= value;
        cfg_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic drive_word(input t_req_word w, input bit known, input t_res_word known_res);
        int unsigned gap;
        if (calm_words != 0) begin
            calm_words--;
            gap = 0;
        end else begin
            gap = gap_len();
            if ($urandom_range(0, 149) == 0) calm_words = $urandom_range(50, 150);
        end
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.operation <= w.op;
        in_ch.data_byte <= w.data;
        in_ch.count <= w.count;
        in_ch.chunk_start <= w.start;
        in_ch.peek_offset <= w.offset;
        word_known = known;
        word_known_res = known_res;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    // result sink pacing
    always @(negedge i_clk) begin : sink_pacing
        if (stall_left != 0) begin
            out_ch.ready <= 1'b0;
            stall_left--;
        end else if (calm_cycles != 0) begin
            out_ch.ready <= 1'b1;
            calm_cycles--;
        end else begin
            stall_left = gap_len();
            if (stall_left != 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
                if ($urandom_range(0, 299) == 0) calm_cycles = $urandom_range(100, 400);
            end
        end
    end

    always @(posedge i_clk) begin : track_words
        t_res_word got, want, calc;
        t_req_word w;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                got.push_accepted = out_ch.push_accepted;
                got.dropped_count = out_ch.dropped_count;
                got.granted_length = out_ch.granted_length;
                got.peek_byte = out_ch.peek_byte;
                got.free_room = out_ch.free_room;
                got.stored_length = out_ch.stored_length;
                if (pending_results.size() == 0) begin
                    note_failure("unexpected result word", '0, got);
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) note_failure("result word mismatch", want, got);
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                ring_capacity = cfg_ch.data;
                ring_head = 0;
                ring_held = 0;
                ring_chunk_ok = 1'b0;
                ring_chunk_left = 0;
            end
            if (in_ch.valid && in_ch.ready) begin
                w.op = in_ch.operation;
                w.data = in_ch.data_byte;
                w.count = in_ch.count;
                w.start = in_ch.chunk_start;
                w.offset = in_ch.peek_offset;
                calc = ring_advance(w);
                pending_results.push_back(word_known ? word_known_res : calc);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin : run_test
        i_rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        in_ch.valid = 1'b0;
        in_ch.operation = OP_PUSH;
        in_ch.data_byte = '0;
        in_ch.count = '0;
        in_ch.chunk_start = 1'b0;
        in_ch.peek_offset = '0;
        out_ch.ready = 1'b0;

        // empty ring, stray words, refused chunks, abandoned chunk, overrun, clamped drop
        add_probe(OP_PEEK, 8'h00, 5,    0, 0,    1, 0, 4096, 0);
        add_probe(OP_DROP, 8'h00, 8191, 0, 0,    1, 0, 4096, 0);
        add_probe(OP_PUSH, 8'h3C, 0,    0, 0,    1, 0, 4096, 0);
        add_probe(OP_NOP,  8'hFF, 8191, 1, 4095, 1, 0, 4096, 0);
        add_probe(OP_PUSH, 8'h77, 0,    1, 0,    1, 0, 4096, 0);
        add_probe(OP_PUSH, 8'h11, 8191, 1, 0,    1, 0, 4096, 0);
        add_probe(OP_PUSH, 8'h22, 4097, 1, 0,    1, 0, 4096, 0);
        add_probe(OP_PUSH, 8'h00, 4096, 1, 0,    1, 1, 4095, 1);
        add_probe(OP_PUSH, 8'hFF, 0,    0, 0,    0, 0, 0, 0);
        add_probe(OP_PUSH, 8'hA5, 0,    0, 0,    0, 0, 0, 0);
        add_probe(OP_PUSH, 8'h5A, 3,    1, 0,    0, 0, 0, 0);
        add_probe(OP_PUSH, 8'hC3, 0,    0, 0,    0, 0, 0, 0);
        add_probe(OP_PUSH, 8'h81, 0,    0, 0,    0, 0, 0, 0);
        add_probe(OP_PUSH, 8'h99, 0,    0, 0,    0, 0, 0, 0);
        add_probe(OP_PEEK, 8'h00, 8191, 0, 0,    0, 0, 0, 0);
        add_probe(OP_PEEK, 8'h00, 8191, 0, 5,    0, 0, 0, 0);
        add_probe(OP_PEEK, 8'h00, 2,    0, 2,    0, 0, 0, 0);
        add_probe(OP_PEEK, 8'h00, 8191, 0, 4095, 0, 0, 0, 0);
        add_probe(OP_PEEK, 8'h00, 0,    0, 0,    0, 0, 0, 0);
        add_probe(OP_DROP, 8'h00, 0,    0, 0,    0, 0, 0, 0);
        add_probe(OP_DROP, 8'h00, 2,    0, 0,    0, 0, 0, 0);
        add_probe(OP_PEEK, 8'h00, 8191, 0, 1,    0, 0, 0, 0);
        add_probe(OP_DROP, 8'h00, 8191, 0, 0,    0, 0, 0, 0);
        add_probe(OP_PEEK, 8'h00, 1,    0, 0,    1, 0, 4096, 0);

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (probe_tab[k]) drive_word(probe_tab[k].w, probe_tab[k].known, probe_tab[k].res);

        foreach (cap_plan[p]) begin
            in_ch.valid <= 1'b0;
            while (pending_results.size() != 0) @(negedge i_clk);
            write_capacity(13'(cap_plan[p]));
            repeat (WORDS_PER_PHASE) drive_word(pick_word(), 1'b0, '0);
        end

        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/rbr_pkg.sv
hw/rtl/rbr_if.sv
hw/rtl/rbr_ram.sv
hw/rtl/rbr_queue.sv
hw/rtl/rbr_front.sv
hw/rtl/rbr_back.sv
hw/rtl/retransmit_byte_ring.sv
hw/rtl/rbr_checker.sv
verif/retransmit_byte_ring_tb.sv
